@@ sv/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// No dependencies; imported by text_console_writer.
package tcw_pkg;

   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CELL_W  = CHAR_W + COLOR_W;

   typedef logic [OP_W-1:0]    op_type;
   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [CELL_W-1:0]  cell_type;

   localparam op_type OP_PUT   = 2'd0;
   localparam op_type OP_PLACE = 2'd1;
   localparam op_type OP_READ  = 2'd2;

   localparam char_type  NEWLINE_CODE = 8'd10;
   localparam char_type  SPACE_CODE   = 8'd32;
   localparam color_type COLOR_RESET  = 8'd7;
   localparam cell_type  BLANK_CELL   = {COLOR_RESET, SPACE_CODE};

   localparam logic REG_TEXT_COLOR = 1'b0;

endpackage

@@ sv/text_console_writer.sv @@
// Top level of the text console writer: screen memory, cursor and control.
// Depends on tcw_pkg for field types, operation codes and the blank cell value.
// After reset the block clears all COLUMNS*ROWS cells, one cell a cycle, while busy
// is high and no transaction is accepted; register writes are taken as ever. A
// transaction is accepted when start is high and busy is low, and its result
// appears on the rsp_ ports, marked by rsp_strobe, for one cycle, in the cycle after
// acceptance unless the put scrolls. Reads, placements and puts that do not scroll
// leave busy low, so a new transaction may be issued in every cycle while no scroll
// runs. A put that moves the cursor past the last row scrolls the screen: the screen
// memory (one read port, one write port) is copied up one row at one cell a cycle,
// busy stays high and the result comes once the copy is done. The receiver cannot
// stall results, so each must be captured in the cycle in which rsp_strobe is high.
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [tcw_pkg::OP_W-1:0]    req_op,
   input  logic [tcw_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [tcw_pkg::COLOR_W-1:0] req_cell_color,
   input  logic [tcw_pkg::COL_W-1:0]   req_cell_col,
   input  logic [tcw_pkg::ROW_W-1:0]   req_cell_row,
   output logic                    rsp_strobe,
   output logic [tcw_pkg::CELL_W-1:0]  rsp_cell_data,
   output logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]   rsp_cursor_col,
   output logic                    rsp_scrolled,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import tcw_pkg::*;

   localparam int CELLS    = COLUMNS * ROWS;
   localparam int MOVES    = COLUMNS * (ROWS - 1);
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int CCOL_W   = $clog2(COLUMNS);
   localparam int CROW_W   = $clog2(ROWS);

   localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_MOVE  = ADDR_W'(MOVES - 1);
   localparam logic [CCOL_W-1:0] LAST_COL   = CCOL_W'(COLUMNS - 1);
   localparam logic [CROW_W-1:0] LAST_ROW   = CROW_W'(ROWS - 1);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_SCROLL = 2'd2;
   localparam logic [1:0] ST_DRAIN  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [CCOL_W-1:0] cursor_col_ff, cursor_col_in;
   logic [CROW_W-1:0] cursor_row_ff, cursor_row_in;
   color_type         text_color_ff, text_color_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_scrolled_ff, rsp_scrolled_in;
   logic              rsp_sel_ff, rsp_sel_in;
   logic              wpend_ff, wpend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   cell_type          rd_data_ff;

   cell_type          mem [CELLS];
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   cell_type          mem_wdata;

   logic              accept, in_range, csr_write;
   logic [ADDR_W-1:0] cursor_addr, req_addr;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign in_range  = (32'(req_cell_col) < COLUMNS) && (32'(req_cell_row) < ROWS);
   assign cursor_addr = ADDR_W'(cursor_row_ff) * COLS_A + ADDR_W'(cursor_col_ff);
   assign req_addr    = ADDR_W'(req_cell_row) * COLS_A + ADDR_W'(req_cell_col);
   assign csr_write = psel && penable && pwrite && pready;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_TEXT_COLOR) ? 32'(text_color_ff) : '0;

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;
   assign rsp_cell_data  = rsp_sel_ff ? rd_data_ff : '0;
   assign rsp_cursor_row = ROW_W'(cursor_row_ff);
   assign rsp_cursor_col = COL_W'(cursor_col_ff);

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      cursor_col_in   = cursor_col_ff;
      cursor_row_in   = cursor_row_ff;
      text_color_in   = text_color_ff;
      rsp_valid_in    = 1'b0;
      rsp_scrolled_in = 1'b0;
      rsp_sel_in      = 1'b0;
      wpend_in        = 1'b0;
      wr_addr_in      = wr_addr_ff;
      mem_we          = 1'b0;
      mem_waddr       = wr_addr_ff;
      mem_wdata       = rd_data_ff;
      mem_re          = 1'b0;
      mem_raddr       = req_addr;

      if (csr_write && paddr[2] == REG_TEXT_COLOR) begin
         text_color_in = pwdata[COLOR_W-1:0];
      end

      if (wpend_ff) begin
         mem_we = 1'b1;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = BLANK_CELL;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (req_op)
                  OP_PUT: begin
                     if (req_char_code != NEWLINE_CODE) begin
                        mem_we    = 1'b1;
                        mem_waddr = cursor_addr;
                        mem_wdata = {text_color_ff, req_char_code};
                     end
                     if (req_char_code == NEWLINE_CODE || cursor_col_ff == LAST_COL) begin
                        cursor_col_in = '0;
                        if (cursor_row_ff == LAST_ROW) begin
                           rsp_valid_in = 1'b0;
                           cnt_in       = '0;
                           state_in     = ST_SCROLL;
                        end else begin
                           cursor_row_in = cursor_row_ff + 1'b1;
                        end
                     end else begin
                        cursor_col_in = cursor_col_ff + 1'b1;
                     end
                  end
                  OP_PLACE: begin
                     if (in_range) begin
                        mem_we    = 1'b1;
                        mem_waddr = req_addr;
                        mem_wdata = {req_cell_color, req_char_code};
                     end
                  end
                  OP_READ: begin
                     if (in_range) begin
                        mem_re     = 1'b1;
                        rsp_sel_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            mem_re     = 1'b1;
            mem_raddr  = cnt_ff + COLS_A;
            wpend_in   = 1'b1;
            wr_addr_in = cnt_ff;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST_MOVE) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rsp_valid_in    = 1'b1;
            rsp_scrolled_in = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         cnt_ff          <= '0;
         cursor_col_ff   <= '0;
         cursor_row_ff   <= '0;
         text_color_ff   <= COLOR_RESET;
         rsp_valid_ff    <= 1'b0;
         rsp_scrolled_ff <= 1'b0;
         rsp_sel_ff      <= 1'b0;
         wpend_ff        <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         cursor_col_ff   <= cursor_col_in;
         cursor_row_ff   <= cursor_row_in;
         text_color_ff   <= text_color_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_scrolled_ff <= rsp_scrolled_in;
         rsp_sel_ff      <= rsp_sel_in;
         wpend_ff        <= wpend_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_scrolled |-> cursor_row_ff == LAST_ROW && cursor_col_ff == '0)
      else $error("scroll result with cursor off the start of the last row");

   a_copy_window: assert property (@(posedge clock) disable iff (reset)
      wpend_ff |-> state_ff == ST_SCROLL || state_ff == ST_DRAIN)
      else $error("pending row copy write outside a scroll");

   a_read_no_stall: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == OP_READ |=> rsp_strobe && !busy)
      else $error("cell read did not answer in the following cycle");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result issued while the block is still busy");

endmodule
